// File: rtl/wsht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test: shared package
// Parameter defaults, command codes, result width and controller states.
// ----------------------------------------------------------------------------
package wsht_pkg;

  localparam int MAX_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int NUM_W           = 5;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/wsht_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test: channel interfaces
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsht_in_if #(
  parameter int COORD_BITS = wsht_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] rect_left;
  logic [COORD_BITS-1:0] rect_bottom;
  logic [COORD_BITS-1:0] rect_right;
  logic [COORD_BITS-1:0] rect_top;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;

  modport source (
    output valid, command, rect_left, rect_bottom, rect_right, rect_top, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, command, rect_left, rect_bottom, rect_right, rect_top, point_x, point_y,
    output ready
  );
endinterface

interface wsht_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [wsht_pkg::NUM_W-1:0] window_number;

  modport source (
    output valid, hit, window_number,
    input  ready
  );
  modport sink (
    input  valid, hit, window_number,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/wsht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsht_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/wsht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test: controller
// Sequencer for add, pipelined top-down scan, order compaction and result.
// ----------------------------------------------------------------------------
module wsht_ctrl #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF,
  parameter int IDX_W       = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  wsht_in_if.sink                      in_ch,
  wsht_out_if.source                   out_ch,
  // rectangle store
  output logic                         rect_we,
  output logic [IDX_W-1:0]             rect_waddr,
  output logic [4*COORD_BITS-1:0]      rect_wdata,
  output logic [IDX_W-1:0]             rect_raddr,
  input  wire logic [4*COORD_BITS-1:0] rect_rdata,
  // stack order store, position 0 is the bottom
  output logic                         ord_we,
  output logic [IDX_W-1:0]             ord_waddr,
  output logic [IDX_W-1:0]             ord_wdata,
  output logic [IDX_W-1:0]             ord_raddr,
  input  wire logic [IDX_W-1:0]        ord_rdata
);

  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int RECT_W = 4 * COORD_BITS;
  localparam int CB     = COORD_BITS;
  localparam int NUM_W  = wsht_pkg::NUM_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOWS);

  wsht_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RECT_W-1:0] rect_r, rect_nxt;
  logic [CB-1:0]     px_r, px_nxt;
  logic [CB-1:0]     py_r, py_nxt;

  // scan pipeline: issue -> order read -> rectangle read -> compare
  logic              iss_vld_r, iss_vld_nxt;
  logic [IDX_W-1:0]  iss_pos_r, iss_pos_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]  s1_pos_r, s1_pos_nxt;
  logic              s2_vld_r, s2_vld_nxt;
  logic [IDX_W-1:0]  s2_pos_r, s2_pos_nxt;
  logic [IDX_W-1:0]  s2_slot_r, s2_slot_nxt;

  // compaction
  logic [IDX_W-1:0]  hit_slot_r, hit_slot_nxt;
  logic [CNT_W-1:0]  sh_rd_r, sh_rd_nxt;
  logic              sh_pend_r, sh_pend_nxt;
  logic [IDX_W-1:0]  sh_wpos_r, sh_wpos_nxt;

  logic              res_hit_r, res_hit_nxt;
  logic [NUM_W-1:0]  res_num_r, res_num_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  sh_prev;
  logic [CNT_W-1:0]  s2_pos_p1;
  logic [IDX_W:0]    slot_p1;
  logic              in_xfer;
  logic              contains;
  logic [CB-1:0]     r_left, r_bottom, r_right, r_top;

  assign cnt_m1    = count_r - CNT_W'(1);
  assign sh_prev   = sh_rd_r - CNT_W'(1);
  assign s2_pos_p1 = CNT_W'(s2_pos_r) + CNT_W'(1);
  assign slot_p1   = {1'b0, hit_slot_r} + (IDX_W+1)'(1);
  assign in_xfer   = in_ch.valid && in_ch.ready;

  assign r_left   = rect_rdata[4*CB-1:3*CB];
  assign r_bottom = rect_rdata[3*CB-1:2*CB];
  assign r_right  = rect_rdata[2*CB-1:CB];
  assign r_top    = rect_rdata[CB-1:0];
  assign contains = (px_r >= r_left) && (px_r <= r_right) &&
                    (py_r >= r_bottom) && (py_r <= r_top);

  assign in_ch.ready          = (state_r == wsht_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.window_number = out_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsht_pkg::ST_IDLE;
      count_r     <= '0;
      iss_vld_r   <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      sh_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_vld_r   <= iss_vld_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      sh_pend_r   <= sh_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rect_r     <= rect_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    iss_pos_r  <= iss_pos_nxt;
    s1_pos_r   <= s1_pos_nxt;
    s2_pos_r   <= s2_pos_nxt;
    s2_slot_r  <= s2_slot_nxt;
    hit_slot_r <= hit_slot_nxt;
    sh_rd_r    <= sh_rd_nxt;
    sh_wpos_r  <= sh_wpos_nxt;
    res_hit_r  <= res_hit_nxt;
    res_num_r  <= res_num_nxt;
    out_hit_r  <= out_hit_nxt;
    out_num_r  <= out_num_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rect_nxt      = rect_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    iss_vld_nxt   = 1'b0;
    iss_pos_nxt   = iss_pos_r;
    s1_vld_nxt    = 1'b0;
    s1_pos_nxt    = iss_pos_r;
    s2_vld_nxt    = 1'b0;
    s2_pos_nxt    = s1_pos_r;
    s2_slot_nxt   = ord_rdata;
    hit_slot_nxt  = hit_slot_r;
    sh_rd_nxt     = sh_rd_r;
    sh_pend_nxt   = 1'b0;
    sh_wpos_nxt   = sh_wpos_r;
    res_hit_nxt   = res_hit_r;
    res_num_nxt   = res_num_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_num_nxt   = out_num_r;

    rect_we    = 1'b0;
    rect_waddr = count_r[IDX_W-1:0];
    rect_wdata = rect_r;
    rect_raddr = ord_rdata;
    ord_we     = 1'b0;
    ord_waddr  = count_r[IDX_W-1:0];
    ord_wdata  = count_r[IDX_W-1:0];
    ord_raddr  = iss_pos_r;

    unique case (state_r)
      wsht_pkg::ST_IDLE: begin
        if (in_xfer) begin
          rect_nxt = {in_ch.rect_left, in_ch.rect_bottom, in_ch.rect_right, in_ch.rect_top};
          px_nxt   = in_ch.point_x;
          py_nxt   = in_ch.point_y;
          if (in_ch.command == wsht_pkg::CMD_ADD) begin
            state_nxt = wsht_pkg::ST_ADD;
          end else if (count_r == '0) begin
            // empty stack: straight to a miss
            res_hit_nxt = 1'b0;
            res_num_nxt = '0;
            state_nxt   = wsht_pkg::ST_RESULT;
          end else begin
            iss_vld_nxt = 1'b1;
            iss_pos_nxt = cnt_m1[IDX_W-1:0];
            state_nxt   = wsht_pkg::ST_SCAN;
          end
        end
      end

      wsht_pkg::ST_ADD: begin
        // drop the add when the table is full
        if (count_r != MAX_CNT) begin
          rect_we   = 1'b1;
          ord_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = wsht_pkg::ST_IDLE;
      end

      wsht_pkg::ST_SCAN: begin
        // advance the pipeline, issuing from the top position downwards
        if (iss_vld_r) begin
          s1_vld_nxt  = 1'b1;
          iss_vld_nxt = (iss_pos_r != '0);
          iss_pos_nxt = iss_pos_r - IDX_W'(1);
        end
        s2_vld_nxt = s1_vld_r;
        if (s2_vld_r && contains) begin
          iss_vld_nxt  = 1'b0;
          s1_vld_nxt   = 1'b0;
          s2_vld_nxt   = 1'b0;
          hit_slot_nxt = s2_slot_r;
          sh_rd_nxt    = s2_pos_p1;
          state_nxt    = wsht_pkg::ST_SHIFT;
        end else if (s2_vld_r && s2_pos_r == '0) begin
          res_hit_nxt = 1'b0;
          res_num_nxt = '0;
          state_nxt   = wsht_pkg::ST_RESULT;
        end
      end

      wsht_pkg::ST_SHIFT: begin
        // close the gap: order[j] <= order[j+1], then the hit slot goes on top
        ord_raddr = sh_rd_r[IDX_W-1:0];
        if (sh_pend_r) begin
          ord_we    = 1'b1;
          ord_waddr = sh_wpos_r;
          ord_wdata = ord_rdata;
        end
        if (sh_rd_r != count_r) begin
          sh_pend_nxt = 1'b1;
          sh_wpos_nxt = sh_prev[IDX_W-1:0];
          sh_rd_nxt   = sh_rd_r + CNT_W'(1);
        end else if (!sh_pend_r) begin
          ord_we      = 1'b1;
          ord_waddr   = cnt_m1[IDX_W-1:0];
          ord_wdata   = hit_slot_r;
          res_hit_nxt = 1'b1;
          res_num_nxt = NUM_W'(slot_p1);
          state_nxt   = wsht_pkg::ST_RESULT;
        end
      end

      wsht_pkg::ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_num_nxt   = res_num_r;
          state_nxt     = wsht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wsht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/window_stack_hit_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test unit
// Z-ordered window stack with inclusive point hit test and move-to-front.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one command per transfer (add a rectangle or click
// at a point); out_ch carries one result transfer per click, none per add.
// Adds number windows from 1 in add order; an add with the table full is
// dropped. A click returns hit with the topmost window containing the point
// (edges inclusive) and moves it to the top; a miss returns hit low, number 0.
// A click scans top down through a three-step pipeline (order read, rectangle
// read, compare), then on a hit compacts the order store from the hit
// position upwards, one entry a cycle, drains the last write and puts the hit
// slot on top; a hit, a miss and a click on an empty stack then load the
// result register. The single write port of the order store sets the
// compaction length. One command is in work at a time.
// The result register parts the two channels: a stalled receiver blocks only
// the next click at its result step, and a new command is taken meanwhile.
// Reset clears the window count and all handshake state; the stores hold
// stale data that is never read before it is rewritten, so no clearing pass.
// ----------------------------------------------------------------------------
module window_stack_hit_test_unit #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsht_in_if.sink    in_ch,
  wsht_out_if.source out_ch
);

  // slot and position index width; at least one bit for a single window
  localparam int IDX_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int RECT_W = 4 * COORD_BITS;

  logic              rect_we;
  logic [IDX_W-1:0]  rect_waddr;
  logic [RECT_W-1:0] rect_wdata;
  logic [IDX_W-1:0]  rect_raddr;
  logic [RECT_W-1:0] rect_rdata;

  logic              ord_we;
  logic [IDX_W-1:0]  ord_waddr;
  logic [IDX_W-1:0]  ord_wdata;
  logic [IDX_W-1:0]  ord_raddr;
  logic [IDX_W-1:0]  ord_rdata;

  // rectangle per slot: {left, bottom, right, top}
  wsht_ram #(
    .WIDTH  (RECT_W),
    .DEPTH  (MAX_WINDOWS),
    .ADDR_W (IDX_W)
  ) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (rect_waddr),
    .wdata (rect_wdata),
    .raddr (rect_raddr),
    .rdata (rect_rdata)
  );

  // slot per stack position; the highest occupied position is the top
  wsht_ram #(
    .WIDTH  (IDX_W),
    .DEPTH  (MAX_WINDOWS),
    .ADDR_W (IDX_W)
  ) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  wsht_ctrl #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .COORD_BITS  (COORD_BITS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .rect_we    (rect_we),
    .rect_waddr (rect_waddr),
    .rect_wdata (rect_wdata),
    .rect_raddr (rect_raddr),
    .rect_rdata (rect_rdata),
    .ord_we     (ord_we),
    .ord_waddr  (ord_waddr),
    .ord_wdata  (ord_wdata),
    .ord_raddr  (ord_raddr),
    .ord_rdata  (ord_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/wsht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test: port checker
// Checks handshake and result behaviour as seen on the top-level ports.
// ----------------------------------------------------------------------------
module wsht_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_hit,
  input wire logic [wsht_pkg::NUM_W-1:0] out_window_number
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_window_number))
    else $error("result changed while stalled");

  // a miss carries number zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_window_number == '0)
    else $error("miss with non-zero window number");

  // one command in work at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // no result appears in the cycle straight after a command transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind window_stack_hit_test_unit wsht_checker u_wsht_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_window_number (out_ch.window_number)
);
`default_nettype wire
